// ----- rtl/assert_macros.svh -----
// Assertion macros for the state feedback motor mixer.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFMM_ASSERT_IMP(label, clk_s, rst_n_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error("sfmm assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SFMM_ASSERT_NXT(label, clk_s, rst_n_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error("sfmm assertion failed");

`endif

// ----- rtl/sfmm_pkg.sv -----
// Shared constants, types and helper functions of the state feedback motor mixer.
// Depends on nothing; used by every module of the block.
package sfmm_pkg;

	localparam int NUM_MOTORS = 4;
	localparam int NUM_STATES = 5;
	localparam int GAIN_DEPTH = NUM_MOTORS * NUM_STATES;

	localparam int GAIN_IDX_W = 5;
	localparam int GAIN_W     = 32;
	localparam int IN_W       = 20;
	localparam int DIFF_W     = IN_W + 1;
	localparam int STATE_W    = 25;
	localparam int PROD_W     = GAIN_W + STATE_W;
	localparam int ACC_W      = 64;
	localparam int HELD_W     = 32;
	localparam int DRIVE_W    = 16;
	localparam int DIV_W      = 4;
	localparam int CNT_W      = 3;

	localparam int FRAC_SHIFT = 16;
	localparam int RAD_Q24    = 292818;

	localparam int MOT_W   = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
	localparam int COL_W   = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
	localparam int STEPS   = NUM_STATES + GAIN_DEPTH;
	localparam int STEP_W  = $clog2(STEPS + 1);

	localparam logic [DIV_W-1:0] DIV_RESET = DIV_W'(2);
	localparam logic [DIV_W-1:0] DIV_MAX   = DIV_W'(8);

	typedef enum logic {
		CMD_SAMPLE  = 1'b0,
		CMD_GAIN_WR = 1'b1
	} cmd_t;

	// Operation handed to the shared multiply unit.
	typedef struct packed {
		logic             valid;
		logic             is_state;
		logic             first;
		logic             last;
		logic [COL_W-1:0] col;
		logic [MOT_W-1:0] row;
	} mac_tag_t;

	typedef struct packed {
		logic               valid;
		logic [COL_W-1:0]   col;
		logic [STATE_W-1:0] value;
	} state_wr_t;

	typedef struct packed {
		logic              valid;
		logic [MOT_W-1:0]  row;
		logic [HELD_W-1:0] value;
	} held_wr_t;

	// Held sum plus thrust, clamped to the drive range; zero thrust stops the motor.
	function automatic logic [DRIVE_W-1:0] drive_f(input logic [HELD_W-1:0] held,
			input logic [DRIVE_W-1:0] thr);
		logic [HELD_W+1:0] total;
		logic [DRIVE_W-1:0] res;
		total = $unsigned($signed({{2{held[HELD_W-1]}}, held})
			+ $signed({2'b00, {(HELD_W-DRIVE_W){1'b0}}, thr}));
		if (thr == '0) begin
			res = '0;
		end else if (total[HELD_W+1]) begin
			res = '0;
		end else if (total[HELD_W:DRIVE_W] != '0) begin
			res = '1;
		end else begin
			res = total[DRIVE_W-1:0];
		end
		return res;
	endfunction

endpackage

// ----- rtl/sfmm_gain_regs.sv -----
// Gain table of the mixer: one entry per motor and state, cleared by reset.
// Depends on sfmm_pkg.
module sfmm_gain_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [sfmm_pkg::GAIN_IDX_W-1:0] wr_index,
	input  logic [sfmm_pkg::GAIN_W-1:0]     wr_data,
	input  logic [sfmm_pkg::GAIN_IDX_W-1:0] rd_index,
	output logic [sfmm_pkg::GAIN_W-1:0]     rd_data
);
	import sfmm_pkg::*;

	logic [GAIN_W-1:0] gain_q [GAIN_DEPTH];

	// Writes to entries past the end of the table are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < GAIN_DEPTH; i++) begin
				gain_q[i] <= '0;
			end
		end else if (wr_en && (wr_index < GAIN_IDX_W'(GAIN_DEPTH))) begin
			gain_q[wr_index] <= wr_data;
		end
	end

	assign rd_data = (rd_index < GAIN_IDX_W'(GAIN_DEPTH)) ? gain_q[rd_index] : '0;

endmodule

// ----- rtl/sfmm_mac.sv -----
// Shared multiply unit with accumulator: converts angle differences to radians
// and forms the gain-by-state sums. Depends on sfmm_pkg.
module sfmm_mac (
	input  logic                         clk,
	input  logic                         arst_n,
	input  sfmm_pkg::mac_tag_t           tag,
	input  logic [sfmm_pkg::GAIN_W-1:0]  op_a,
	input  logic [sfmm_pkg::STATE_W-1:0] op_b,
	output sfmm_pkg::state_wr_t          state_wr,
	output sfmm_pkg::held_wr_t           held_wr,
	output logic                         busy
);
	import sfmm_pkg::*;

	localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (FRAC_SHIFT - 1);

	mac_tag_t                 tag_s1;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  prod_ext;
	logic signed [ACC_W-1:0]  acc_next;
	logic signed [PROD_W-1:0] round_sum;
	logic signed [GAIN_W-1:0]  a_s;
	logic signed [STATE_W-1:0] b_s;

	assign a_s = $signed(op_a);
	assign b_s = $signed(op_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1 <= tag;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= a_s * b_s;
	end

	assign prod_ext  = {{(ACC_W-PROD_W){prod_s1[PROD_W-1]}}, prod_s1};
	assign acc_next  = tag_s1.first ? prod_ext : acc_q + prod_ext;
	assign round_sum = prod_s1 + ROUND_HALF;

	always_ff @(posedge clk) begin
		if (tag_s1.valid && !tag_s1.is_state) begin
			acc_q <= acc_next;
		end
	end

	assign state_wr.valid = tag_s1.valid && tag_s1.is_state;
	assign state_wr.col   = tag_s1.col;
	assign state_wr.value = round_sum[STATE_W+FRAC_SHIFT-1:FRAC_SHIFT];

	// The sum of all products stays within 60 bits, so its upper word is always
	// a valid signed 32-bit value and needs no saturation.
	assign held_wr.valid = tag_s1.valid && !tag_s1.is_state && tag_s1.last;
	assign held_wr.row   = tag_s1.row;
	assign held_wr.value = acc_next[ACC_W-1:ACC_W-HELD_W];

	assign busy = tag_s1.valid;

endmodule

// ----- rtl/state_feedback_motor_mixer.sv -----
// Top level of the state feedback motor mixer: sequencer, sample registers,
// held sums and motor output lanes. Depends on sfmm_pkg, sfmm_gain_regs, sfmm_mac
// and assert_macros.svh.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------------
//  in      | to block  | in_valid / in_stall  | command, gain_index, gain_value, sensors
//  out     | from block| out_valid / out_stall| motor_one .. motor_four
//  cfg     | to block  | cfg_valid / cfg_ready| cfg_data (update_divider)
//
// A gain write is taken in the idle state. A control sample without recomputation
// goes from the idle state straight to the output state; with recomputation it runs
// 25 serial operations (five radian conversions, twenty gain products) through the one
// shared multiplier and its pipe, then drains the pipe before the output state. Reset
// clears the gain table, held sums and divider count.
// A stalled result holds the sequencer in its output state; in_stall stays high then.
`include "assert_macros.svh"

module state_feedback_motor_mixer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                command,
	input  logic [sfmm_pkg::GAIN_IDX_W-1:0]     gain_index,
	input  logic signed [sfmm_pkg::GAIN_W-1:0]  gain_value,
	input  logic signed [sfmm_pkg::IN_W-1:0]    rate_roll,
	input  logic signed [sfmm_pkg::IN_W-1:0]    rate_pitch,
	input  logic signed [sfmm_pkg::IN_W-1:0]    rate_yaw,
	input  logic signed [sfmm_pkg::IN_W-1:0]    roll_estimate,
	input  logic signed [sfmm_pkg::IN_W-1:0]    pitch_estimate,
	input  logic signed [sfmm_pkg::IN_W-1:0]    roll_setpoint,
	input  logic signed [sfmm_pkg::IN_W-1:0]    pitch_setpoint,
	input  logic signed [sfmm_pkg::IN_W-1:0]    yaw_rate_setpoint,
	input  logic [sfmm_pkg::DRIVE_W-1:0]        thrust,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [sfmm_pkg::DRIVE_W-1:0]        motor_one,
	output logic [sfmm_pkg::DRIVE_W-1:0]        motor_two,
	output logic [sfmm_pkg::DRIVE_W-1:0]        motor_three,
	output logic [sfmm_pkg::DRIVE_W-1:0]        motor_four,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [sfmm_pkg::DIV_W-1:0]          cfg_data
);
	import sfmm_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CALC  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_OUT   = 4'b1000
	} seq_state_t;

	seq_state_t          state_q;
	logic [DIV_W-1:0]    div_q;
	logic [DIV_W-1:0]    div_eff;
	logic [CNT_W-1:0]    count_q;
	logic                recompute;
	logic                in_acc;
	logic                sample_acc;
	logic                gain_acc;
	logic                out_load;

	logic [DIFF_W-1:0]   diff_q [NUM_STATES];
	logic [DRIVE_W-1:0]  thrust_q;
	logic [STATE_W-1:0]  state_val_q [NUM_STATES];
	logic [HELD_W-1:0]   held_q [NUM_MOTORS];
	logic [DRIVE_W-1:0]  motor_q [NUM_MOTORS];
	logic                out_valid_q;

	logic [STEP_W-1:0]     step_q;
	logic [COL_W-1:0]      col_q;
	logic [MOT_W-1:0]      row_q;
	logic [GAIN_IDX_W-1:0] gidx_q;
	logic                  state_phase;
	logic                  col_wrap;

	mac_tag_t            tag;
	logic [GAIN_W-1:0]   op_a;
	logic [STATE_W-1:0]  op_b;
	logic [GAIN_W-1:0]   gain_rd;
	state_wr_t           state_wr;
	held_wr_t            held_wr;
	logic                mac_busy;

	assign in_acc     = in_valid && !in_stall;
	assign sample_acc = in_acc && (command == CMD_SAMPLE);
	assign gain_acc   = in_acc && (command == CMD_GAIN_WR);
	assign in_stall   = (state_q != ST_IDLE);
	assign cfg_ready  = 1'b1;

	// A divider of zero acts as one, anything above eight as eight.
	always_comb begin
		if (div_q == '0) begin
			div_eff = DIV_W'(1);
		end else if (div_q > DIV_MAX) begin
			div_eff = DIV_MAX;
		end else begin
			div_eff = div_q;
		end
	end

	assign recompute = ({1'b0, count_q} + DIV_W'(1)) >= div_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q <= DIV_RESET;
		end else if (cfg_valid && cfg_ready) begin
			div_q <= cfg_data;
		end
	end

	sfmm_gain_regs u_gain (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (gain_acc),
		.wr_index (gain_index),
		.wr_data  (gain_value),
		.rd_index (gidx_q),
		.rd_data  (gain_rd)
	);

	assign state_phase = (step_q < STEP_W'(NUM_STATES));
	assign col_wrap    = (col_q == COL_W'(NUM_STATES - 1));

	// The first steps turn each rate or angle error into radians, the rest run the
	// gain products row by row.
	always_comb begin
		tag.valid    = (state_q == ST_CALC);
		tag.is_state = state_phase;
		tag.first    = (col_q == '0);
		tag.last     = col_wrap;
		tag.col      = col_q;
		tag.row      = row_q;
		if (state_phase) begin
			op_a = {{(GAIN_W-DIFF_W){diff_q[col_q][DIFF_W-1]}}, diff_q[col_q]};
			op_b = STATE_W'(RAD_Q24);
		end else begin
			op_a = gain_rd;
			op_b = state_val_q[col_q];
		end
	end

	sfmm_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.tag      (tag),
		.op_a     (op_a),
		.op_b     (op_b),
		.state_wr (state_wr),
		.held_wr  (held_wr),
		.busy     (mac_busy)
	);

	always_ff @(posedge clk) begin
		if (sample_acc) begin
			thrust_q  <= thrust;
			diff_q[0] <= {rate_roll[IN_W-1], rate_roll};
			diff_q[1] <= {rate_pitch[IN_W-1], rate_pitch};
			diff_q[2] <= DIFF_W'($signed({yaw_rate_setpoint[IN_W-1], yaw_rate_setpoint})
				- $signed({rate_yaw[IN_W-1], rate_yaw}));
			diff_q[3] <= DIFF_W'($signed({roll_setpoint[IN_W-1], roll_setpoint})
				- $signed({roll_estimate[IN_W-1], roll_estimate}));
			diff_q[4] <= DIFF_W'($signed({pitch_setpoint[IN_W-1], pitch_setpoint})
				- $signed({pitch_estimate[IN_W-1], pitch_estimate}));
		end
		if (state_wr.valid) begin
			state_val_q[state_wr.col] <= state_wr.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int m = 0; m < NUM_MOTORS; m++) begin
				held_q[m] <= '0;
			end
		end else if (held_wr.valid) begin
			held_q[held_wr.row] <= held_wr.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			step_q  <= '0;
			col_q   <= '0;
			row_q   <= '0;
			gidx_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					col_q  <= '0;
					row_q  <= '0;
					gidx_q <= '0;
					if (sample_acc) begin
						if (recompute) begin
							count_q <= '0;
							state_q <= ST_CALC;
						end else begin
							count_q <= count_q + CNT_W'(1);
							state_q <= ST_OUT;
						end
					end
				end
				ST_CALC: begin
					step_q <= step_q + STEP_W'(1);
					col_q  <= col_wrap ? '0 : col_q + COL_W'(1);
					if (!state_phase) begin
						gidx_q <= gidx_q + GAIN_IDX_W'(1);
						if (col_wrap) begin
							row_q <= row_q + MOT_W'(1);
						end
					end
					if (step_q == STEP_W'(STEPS - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!mac_busy) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			for (int m = 0; m < NUM_MOTORS; m++) begin
				motor_q[m] <= drive_f(held_q[m], thrust_q);
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign motor_one   = motor_q[0];
	assign motor_two   = motor_q[1];
	assign motor_three = motor_q[2];
	assign motor_four  = motor_q[3];

	`SFMM_ASSERT_NXT(a_sample_blocks, clk, arst_n, sample_acc, in_stall)
	`SFMM_ASSERT_IMP(a_held_in_calc, clk, arst_n, held_wr.valid,
		(state_q == ST_CALC) || (state_q == ST_DRAIN))
	`SFMM_ASSERT_IMP(a_idle_pipe_empty, clk, arst_n, state_q == ST_IDLE, !mac_busy)
	`SFMM_ASSERT_IMP(a_load_in_out, clk, arst_n, out_load, !tag.valid && !mac_busy)

endmodule

// ----- sim/tb_state_feedback_motor_mixer.sv -----
// Self-checking testbench for the state feedback motor mixer: a directed table, then
// random phases under several divider settings and idling patterns. Needs sfmm_pkg
// and state_feedback_motor_mixer; motor drives are checked against a local predictor.
module tb_state_feedback_motor_mixer;
	timeunit 1ns;
	timeprecision 1ps;

	import sfmm_pkg::*;

	typedef logic signed [IN_W-1:0] sensor_t;

	typedef struct packed {
		cmd_t                     command;
		logic [GAIN_IDX_W-1:0]    gain_index;
		logic signed [GAIN_W-1:0] gain_value;
		sensor_t                  rate_roll;
		sensor_t                  rate_pitch;
		sensor_t                  rate_yaw;
		sensor_t                  roll_estimate;
		sensor_t                  pitch_estimate;
		sensor_t                  roll_setpoint;
		sensor_t                  pitch_setpoint;
		sensor_t                  yaw_rate_setpoint;
		logic [DRIVE_W-1:0]       thrust;
	} sample_t;

	// Index 0 is motor one.
	typedef logic [NUM_MOTORS-1:0][DRIVE_W-1:0] drive_t;

	typedef struct packed {
		sample_t            item;
		logic               fixed_want;
		logic [DRIVE_W-1:0] want;
	} dir_row_t;

	localparam sensor_t S_MAX  = 20'sh7FFFF;
	localparam sensor_t S_MIN  = 20'sh80000;
	localparam sensor_t S_ZERO = '0;

	localparam int DIR_ROWS      = 18;
	localparam int PHASES        = 6;
	localparam int PHASE_ITEMS   = 175;
	localparam int IDLE_LIMIT    = 3000;
	localparam int SETTLE_CYCLES = 40;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic                     command = 1'b0;
	logic [GAIN_IDX_W-1:0]    gain_index = '0;
	logic signed [GAIN_W-1:0] gain_value = '0;
	sensor_t                  rate_roll = '0;
	sensor_t                  rate_pitch = '0;
	sensor_t                  rate_yaw = '0;
	sensor_t                  roll_estimate = '0;
	sensor_t                  pitch_estimate = '0;
	sensor_t                  roll_setpoint = '0;
	sensor_t                  pitch_setpoint = '0;
	sensor_t                  yaw_rate_setpoint = '0;
	logic [DRIVE_W-1:0]       thrust = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [DRIVE_W-1:0]       motor_one;
	logic [DRIVE_W-1:0]       motor_two;
	logic [DRIVE_W-1:0]       motor_three;
	logic [DRIVE_W-1:0]       motor_four;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [DIV_W-1:0]         cfg_data = '0;

	// Predictor state.
	logic signed [GAIN_W-1:0] gain_tab [GAIN_DEPTH];
	logic signed [HELD_W-1:0] held_sum [NUM_MOTORS];
	logic [CNT_W-1:0]         sample_cnt;
	logic [DIV_W-1:0]         divider;

	drive_t awaited_drives [$];

	int errors = 0;
	int samples_sent = 0;
	int gain_writes = 0;
	int idle_cycles = 0;
	int send_gap_pct = 0;
	int recv_stall_pct = 0;

	logic [DIV_W-1:0] phase_div [PHASES] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd6};

	dir_row_t dir_rows [DIR_ROWS] = '{
		// Zero gains after reset: each drive is the thrust alone.
		'{'{CMD_SAMPLE, 5'd0, 32'sd0, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX,
			S_MAX, 16'd0}, 1'b1, 16'd0},
		'{'{CMD_SAMPLE, 5'd0, 32'sd0, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN,
			S_MIN, 16'hFFFF}, 1'b1, 16'hFFFF},
		'{'{CMD_SAMPLE, 5'd0, 32'sd0, S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO,
			S_ZERO, S_ZERO, 16'd1}, 1'b1, 16'd1},
		'{'{CMD_GAIN_WR, 5'd0, 32'sh7FFF_FFFF, S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO,
			S_ZERO, S_ZERO, S_ZERO, 16'd0}, 1'b0, 16'd0},
		'{'{CMD_GAIN_WR, 5'd19, 32'h8000_0000, S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO,
			S_ZERO, S_ZERO, S_ZERO, 16'd0}, 1'b0, 16'd0},
		// Indexes past the table are dropped.
		'{'{CMD_GAIN_WR, 5'd20, 32'h1234_5678, S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO,
			S_ZERO, S_ZERO, S_ZERO, 16'd0}, 1'b0, 16'd0},
		'{'{CMD_GAIN_WR, 5'd31, 32'hFFFF_FFFF, S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO,
			S_ZERO, S_ZERO, S_ZERO, 16'd0}, 1'b0, 16'd0},
		'{'{CMD_GAIN_WR, 5'd7, 32'h0400_0000, S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO,
			S_ZERO, S_ZERO, S_ZERO, 16'd0}, 1'b0, 16'd0},
		'{'{CMD_GAIN_WR, 5'd13, 32'hFC00_0000, S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO,
			S_ZERO, S_ZERO, S_ZERO, 16'd0}, 1'b0, 16'd0},
		'{'{CMD_GAIN_WR, 5'd4, 32'h0010_0000, S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO,
			S_ZERO, S_ZERO, S_ZERO, 16'd0}, 1'b0, 16'd0},
		'{'{CMD_GAIN_WR, 5'd16, 32'hFFF0_0000, S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO,
			S_ZERO, S_ZERO, S_ZERO, 16'd0}, 1'b0, 16'd0},
		// Largest errors of either sign, with a recomputation.
		'{'{CMD_SAMPLE, 5'd0, 32'sd0, S_MAX, S_MIN, S_MIN, S_MIN, S_MAX, S_MAX, S_MIN,
			S_MAX, 16'd32768}, 1'b0, 16'd0},
		'{'{CMD_SAMPLE, 5'd0, 32'sd0, S_MAX, S_MIN, S_MIN, S_MIN, S_MAX, S_MAX, S_MIN,
			S_MAX, 16'hFFFF}, 1'b0, 16'd0},
		// Zero thrust on a sample that also recomputes the sums.
		'{'{CMD_SAMPLE, 5'd0, 32'sd0, S_MIN, S_MAX, S_MAX, S_MAX, S_MIN, S_MIN, S_MAX,
			S_MIN, 16'd0}, 1'b1, 16'd0},
		'{'{CMD_SAMPLE, 5'd0, 32'sd0, S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO,
			S_ZERO, S_ZERO, 16'd1}, 1'b0, 16'd0},
		'{'{CMD_SAMPLE, 5'd0, 32'sd0, S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO,
			S_ZERO, S_ZERO, 16'd100}, 1'b0, 16'd0},
		'{'{CMD_GAIN_WR, 5'd0, 32'sd0, S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO,
			S_ZERO, S_ZERO, S_ZERO, 16'd0}, 1'b0, 16'd0},
		'{'{CMD_SAMPLE, 5'd0, 32'sd0, 20'sd2560, -20'sd1280, 20'sd640, 20'sd300,
			-20'sd700, -20'sd256, 20'sd512, -20'sd900, 16'd40000}, 1'b0, 16'd0}
	};

	state_feedback_motor_mixer u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.command          (command),
		.gain_index       (gain_index),
		.gain_value       (gain_value),
		.rate_roll        (rate_roll),
		.rate_pitch       (rate_pitch),
		.rate_yaw         (rate_yaw),
		.roll_estimate    (roll_estimate),
		.pitch_estimate   (pitch_estimate),
		.roll_setpoint    (roll_setpoint),
		.pitch_setpoint   (pitch_setpoint),
		.yaw_rate_setpoint(yaw_rate_setpoint),
		.thrust           (thrust),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.motor_one        (motor_one),
		.motor_two        (motor_two),
		.motor_three      (motor_three),
		.motor_four       (motor_four),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data)
	);

	always #5 clk = ~clk;

	// Angle or rate difference (1/256 degree) to Q16 radians, rounded half up.
	function automatic longint to_rad_q16(input longint diff);
		return (diff * longint'(RAD_Q24) + 64'sd32768) >>> FRAC_SHIFT;
	endfunction

	// Advances the mixer state by one item; returns 1 when the item yields drives.
	function automatic bit mix_step(input sample_t s, output drive_t d);
		longint st [NUM_STATES];
		longint acc;
		longint h;
		longint total;
		int lim;
		d = '0;
		if (s.command == CMD_GAIN_WR) begin
			if (s.gain_index < GAIN_DEPTH)
				gain_tab[s.gain_index] = s.gain_value;
			return 1'b0;
		end
		lim = int'(divider);
		if (lim < 1)
			lim = 1;
		if (lim > 8)
			lim = 8;
		if (int'(sample_cnt) + 1 >= lim) begin
			sample_cnt = '0;
			st[0] = to_rad_q16(longint'(s.rate_roll));
			st[1] = to_rad_q16(longint'(s.rate_pitch));
			st[2] = to_rad_q16(longint'(s.yaw_rate_setpoint) - longint'(s.rate_yaw));
			st[3] = to_rad_q16(longint'(s.roll_setpoint) - longint'(s.roll_estimate));
			st[4] = to_rad_q16(longint'(s.pitch_setpoint) - longint'(s.pitch_estimate));
			for (int m = 0; m < NUM_MOTORS; m++) begin
				acc = 0;
				for (int k = 0; k < NUM_STATES; k++)
					acc += longint'(gain_tab[m * NUM_STATES + k]) * st[k];
				h = acc >>> 32;
				if (h > 64'sd2147483647)
					h = 64'sd2147483647;
				if (h < -64'sd2147483648)
					h = -64'sd2147483648;
				held_sum[m] = HELD_W'(h);
			end
		end else begin
			sample_cnt = sample_cnt + 1'b1;
		end
		for (int m = 0; m < NUM_MOTORS; m++) begin
			if (s.thrust != '0) begin
				total = longint'(held_sum[m]) + longint'(s.thrust);
				if (total < 0)
					d[m] = '0;
				else if (total > 65535)
					d[m] = '1;
				else
					d[m] = DRIVE_W'(total);
			end
		end
		return 1'b1;
	endfunction

	// Modest angles half the time so that the drives stay off their limits, else full-range values or extremes.
	function automatic sensor_t rand_sensor();
		sensor_t v;
		case ($urandom_range(7))
			0: v = S_MAX;
			1: v = S_MIN;
			2, 3: v = IN_W'($urandom);
			default: v = IN_W'($urandom_range(32768)) - IN_W'(16384);
		endcase
		return v;
	endfunction

	function automatic logic signed [GAIN_W-1:0] rand_gain();
		logic signed [GAIN_W-1:0] v;
		if ($urandom_range(3) == 0)
			v = $urandom;
		else
			v = GAIN_W'($urandom_range(32'h0800_0000)) - 32'h0400_0000;
		return v;
	endfunction

	function automatic logic [DRIVE_W-1:0] rand_thrust();
		logic [DRIVE_W-1:0] v;
		case ($urandom_range(9))
			0: v = '0;
			1: v = '1;
			2: v = 16'd1;
			default: v = DRIVE_W'($urandom);
		endcase
		return v;
	endfunction

	function automatic sample_t rand_sample(input cmd_t c);
		sample_t s;
		s.command           = c;
		s.gain_index        = GAIN_IDX_W'($urandom_range(GAIN_DEPTH - 1));
		s.gain_value        = rand_gain();
		s.rate_roll         = rand_sensor();
		s.rate_pitch        = rand_sensor();
		s.rate_yaw          = rand_sensor();
		s.roll_estimate     = rand_sensor();
		s.pitch_estimate    = rand_sensor();
		s.roll_setpoint     = rand_sensor();
		s.pitch_setpoint    = rand_sensor();
		s.yaw_rate_setpoint = rand_sensor();
		s.thrust            = rand_thrust();
		return s;
	endfunction

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic send_item(input sample_t s, input bit fixed_want,
			input logic [DRIVE_W-1:0] want);
		drive_t d;
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		command           <= s.command;
		gain_index        <= s.gain_index;
		gain_value        <= s.gain_value;
		rate_roll         <= s.rate_roll;
		rate_pitch        <= s.rate_pitch;
		rate_yaw          <= s.rate_yaw;
		roll_estimate     <= s.roll_estimate;
		pitch_estimate    <= s.pitch_estimate;
		roll_setpoint     <= s.roll_setpoint;
		pitch_setpoint    <= s.pitch_setpoint;
		yaw_rate_setpoint <= s.yaw_rate_setpoint;
		thrust            <= s.thrust;
		in_valid          <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		if (mix_step(s, d)) begin
			if (fixed_want)
				d = {NUM_MOTORS{want}};
			awaited_drives.push_back(d);
			samples_sent++;
		end else begin
			gain_writes++;
		end
		@(negedge clk);
	endtask

	// The divider is only changed once the mixer has drained and any sum is finished.
	task automatic write_divider(input logic [DIV_W-1:0] v);
		in_valid <= 1'b0;
		while (awaited_drives.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_data  <= v;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		divider = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input int n);
		sample_t s;
		int counted;
		int r;
		counted = 0;
		while (counted < n) begin
			r = $urandom_range(99);
			if (r < 2) begin
				// Reload the whole gain table in order, as a flight controller would.
				for (int i = 0; i < GAIN_DEPTH; i++) begin
					s = rand_sample(CMD_GAIN_WR);
					s.gain_index = GAIN_IDX_W'(i);
					send_item(s, 1'b0, '0);
				end
				counted += GAIN_DEPTH;
			end else if (r < 8) begin
				s = rand_sample(CMD_GAIN_WR);
				s.gain_index = GAIN_IDX_W'($urandom_range(31));
				send_item(s, 1'b0, '0);
				if (s.gain_index < GAIN_DEPTH)
					counted++;
			end else begin
				send_item(rand_sample(CMD_SAMPLE), 1'b0, '0);
				counted++;
			end
		end
	endtask

	always @(negedge clk)
		out_stall <= ($urandom_range(99) < recv_stall_pct);

	always @(posedge clk) begin : drive_check
		drive_t got;
		drive_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = {motor_four, motor_three, motor_two, motor_one};
			if (awaited_drives.size() == 0) begin
				errors++;
				$display("%0t: drives %h arrived with no sample pending", $time, got);
			end else begin
				want = awaited_drives.pop_front();
				for (int m = 0; m < NUM_MOTORS; m++) begin
					if (got[m] !== want[m]) begin
						errors++;
						$display("%0t: motor %0d expected %0d, got %0d", $time, m + 1,
							want[m], got[m]);
					end
				end
			end
		end
	end

	// Counts cycles with no transaction on any channel.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < GAIN_DEPTH; i++)
			gain_tab[i] = '0;
		for (int m = 0; m < NUM_MOTORS; m++)
			held_sum[m] = '0;
		sample_cnt = '0;
		divider = DIV_RESET;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		send_gap_pct = 35;
		recv_stall_pct = 54;
		for (int i = 0; i < DIR_ROWS; i++)
			send_item(dir_rows[i].item, dir_rows[i].fixed_want, dir_rows[i].want);
		for (int p = 0; p < PHASES; p++) begin
			write_divider(phase_div[p]);
			send_gap_pct = (p < 2) ? 35 : (p < 4) ? 54 : 0;
			recv_stall_pct = (p < 2) ? 54 : (p < 4) ? 35 : 0;
			run_phase(PHASE_ITEMS);
		end
		in_valid <= 1'b0;
		while (awaited_drives.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Checked %0d control samples and applied %0d gain writes,", samples_sent,
			gain_writes);
		$display("over dividers 2, 1, 8, 0, 15, 3 and 6 with varied idling; %0d mismatches.",
			errors);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
